// ===== rtl/tgh_pkg.sv =====
package tgh_pkg;

  // Granularity codes held in the configuration register. Code seven has no
  // meaning and is handled like raw.
  typedef enum logic [2:0] {
    GRAN_RAW    = 3'd0,
    GRAN_SECOND = 3'd1,
    GRAN_MINUTE = 3'd2,
    GRAN_HOUR   = 3'd3,
    GRAN_DAY    = 3'd4,
    GRAN_WEEK   = 3'd5,
    GRAN_MONTH  = 3'd6
  } gran_mode_e;

  localparam int unsigned TS_W      = 64;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned NUM_RADIX = 6;
  localparam int unsigned DIG_W     = 6;   // widest digit is below 60
  localparam int unsigned QUO_W     = 20;  // whole periods of 29030400 s
  localparam int unsigned REM_W     = 28;  // remainder of the period division
  localparam int unsigned Y_W       = 39;  // (ts mod period) >> 6
  localparam int unsigned SEC_W     = 25;  // seconds inside one period

  // The period is 29030400 s = 2^17 * 221484375 us. The timestamp is shifted
  // right by 17 and divided by the odd part.
  localparam int unsigned PERIOD_SHIFT = 17;
  localparam logic [REM_W-1:0] PERIOD_ODD = 28'd221484375;
  localparam logic [47:0] RECIP_PERIOD =
    48'(((96'd1 << 75) + 96'(PERIOD_ODD) - 96'd1) / 96'(PERIOD_ODD));
  localparam int unsigned RECIP_PERIOD_SHIFT = 75;

  // One microsecond scale: 1000000 = 2^6 * 15625.
  localparam logic [39:0] RECIP_US =
    40'(((64'd1 << 53) + 64'd15624) / 64'd15625);
  localparam int unsigned RECIP_US_SHIFT = 53;

  localparam logic [SEC_W-1:0] SECS_PER_PERIOD = 25'd29030400;

  localparam int unsigned RADIX [NUM_RADIX] = '{60, 60, 24, 7, 4, 12};

  // Reciprocals for floor(sec / 60), / 3600, / 86400, / 604800, / 2419200
  // on 25-bit values, exact for the whole range.
  localparam logic [25:0] RECIP_DIG [NUM_RADIX-1] = '{
    26'(((64'd1 << 31) + 64'd59) / 64'd60),
    26'(((64'd1 << 37) + 64'd3599) / 64'd3600),
    26'(((64'd1 << 42) + 64'd86399) / 64'd86400),
    26'(((64'd1 << 45) + 64'd604799) / 64'd604800),
    26'(((64'd1 << 47) + 64'd2419199) / 64'd2419200)
  };
  localparam int unsigned DIG_SHIFT [NUM_RADIX-1] = '{31, 37, 42, 45, 47};

  // Weight of each digit (second .. month) per mode: the all-ones word
  // divided by the product of the radices visited up to that digit.
  localparam logic [TS_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [TS_W-1:0] WEIGHT [8][NUM_RADIX] = '{
    '{6{64'd0}},
    '{ALL_ONES / 64'd60,       ALL_ONES / 64'd3600,   ALL_ONES / 64'd86400,
      ALL_ONES / 64'd604800,   ALL_ONES / 64'd2419200, ALL_ONES / 64'd29030400},
    '{ALL_ONES / 64'd3600,     ALL_ONES / 64'd60,     ALL_ONES / 64'd86400,
      ALL_ONES / 64'd604800,   ALL_ONES / 64'd2419200, ALL_ONES / 64'd29030400},
    '{ALL_ONES / 64'd86400,    ALL_ONES / 64'd1440,   ALL_ONES / 64'd24,
      ALL_ONES / 64'd604800,   ALL_ONES / 64'd2419200, ALL_ONES / 64'd29030400},
    '{ALL_ONES / 64'd604800,   ALL_ONES / 64'd10080,  ALL_ONES / 64'd168,
      ALL_ONES / 64'd7,        ALL_ONES / 64'd2419200, ALL_ONES / 64'd29030400},
    '{ALL_ONES / 64'd2419200,  ALL_ONES / 64'd40320,  ALL_ONES / 64'd672,
      ALL_ONES / 64'd28,       ALL_ONES / 64'd4,       ALL_ONES / 64'd29030400},
    '{ALL_ONES / 64'd29030400, ALL_ONES / 64'd483840, ALL_ONES / 64'd8064,
      ALL_ONES / 64'd336,      ALL_ONES / 64'd48,      ALL_ONES / 64'd12},
    '{6{64'd0}}
  };

  function automatic logic is_hashed(logic [MODE_W-1:0] mode);
    return (mode >= GRAN_SECOND) && (mode <= GRAN_MONTH);
  endfunction

endpackage

// ===== rtl/timestamp_granularity_hash_top.sv =====
// A result travels to the master side through twelve register stages.
// Throughput: one item per cycle; every stage is a plain pipeline register.
// A stall on the master side freezes all stages together, so nothing is lost.
// Reset clears the stage valid bits and sets the mode register to raw.
module timestamp_granularity_hash_top
  import tgh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TS_W-1:0]   s_axis_tdata,   // [63:0] timestamp_us
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TS_W-1:0]   m_axis_tdata    // [63:0] hash_value
);

  localparam int unsigned NUM_STAGES = 12;

  // The hash splits the timestamp into whole periods of 29030400 seconds (the
  // remainder digit) and the seconds inside one period. Those seconds are then
  // taken apart into second, minute, hour, day, week and month digits, each
  // digit is scaled by a mode dependent weight and everything is summed.
  //
  // Stage  1: partial products of (ts >> 17) times the period reciprocal.
  // Stage  2: sum of the partial products gives the period count.
  // Stage  3: period count times the odd part of the period.
  // Stage  4: remainder inside the period, scaled down by 2^6.
  // Stage  5: partial products for the division by 15625.
  // Stage  6: seconds inside the period.
  // Stage  7: seconds divided by the cumulative radices, low bits kept.
  // Stage  8: digits from neighboring quotients.
  // Stage  9: digit times weight.
  // Stage 10-11: adder tree.
  // Stage 12: final add, raw select, output register.

  logic [MODE_W-1:0] cfg_mode_q;

  logic [NUM_STAGES-1:0] v_q;
  logic                  pipe_en;

  logic [TS_W-1:0]   ts_q   [NUM_STAGES-1];
  logic [MODE_W-1:0] mode_q [NUM_STAGES-1];
  logic [QUO_W-1:0]  qt_q   [8];

  logic [47:0]       qpp_q [4];
  logic [47:0]       qpp_d [4];
  logic [QUO_W-1:0]  qt_d;
  logic [REM_W-1:0]  qd_q, qd_d;
  logic [Y_W-1:0]    y_q, y_d;
  logic [39:0]       spp_q [4];
  logic [39:0]       spp_d [4];
  logic [SEC_W-1:0]  sec_q, sec_d;
  logic [DIG_W-1:0]  quo_q [NUM_RADIX];
  logic [DIG_W-1:0]  quo_d [NUM_RADIX];
  logic [DIG_W-1:0]  dig_q [NUM_RADIX];
  logic [DIG_W-1:0]  dig_d [NUM_RADIX];
  logic [TS_W-1:0]   term_q [NUM_RADIX];
  logic [TS_W-1:0]   term_d [NUM_RADIX];
  logic [TS_W-1:0]   psum_q [4];
  logic [TS_W-1:0]   psum_d [4];
  logic [TS_W-1:0]   fsum_q [2];
  logic [TS_W-1:0]   fsum_d [2];
  logic [TS_W-1:0]   hash_q, hash_d;

  // The whole pipeline advances unless a finished result waits at the output.
  assign pipe_en       = !v_q[NUM_STAGES-1] || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = v_q[NUM_STAGES-1];
  assign m_axis_tdata  = hash_q;

  // Configuration register, written only while the block is idle: a rule for the user, not enforced here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q <= GRAN_RAW;
    end else if (cfg_we_i) begin
      cfg_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_en) begin
      v_q <= {v_q[NUM_STAGES-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: the 47-bit shifted timestamp times the 48-bit reciprocal, cut
  // into four partial products of pieces up to 24 bits wide.
  always_comb begin
    logic [46:0] t;
    t = s_axis_tdata[TS_W-1:PERIOD_SHIFT];
    qpp_d[0] = 48'(t[23:0])  * 48'(RECIP_PERIOD[23:0]);
    qpp_d[1] = 48'(t[23:0])  * 48'(RECIP_PERIOD[47:24]);
    qpp_d[2] = 48'(t[46:24]) * 48'(RECIP_PERIOD[23:0]);
    qpp_d[3] = 48'(t[46:24]) * 48'(RECIP_PERIOD[47:24]);
  end

  // Stage 2: the period count is the top of the full product.
  always_comb begin
    logic [94:0] qsum;
    qsum = 95'(qpp_q[0]) + ((95'(qpp_q[1]) + 95'(qpp_q[2])) << 24)
         + (95'(qpp_q[3]) << 48);
    qt_d = qsum[RECIP_PERIOD_SHIFT +: QUO_W];
  end

  // Stage 3: only the low bits of the product matter, since the remainder
  // is known to be below the odd part of the period.
  always_comb begin
    logic [47:0] qd;
    qd   = 48'(qt_q[0]) * 48'(PERIOD_ODD);
    qd_d = qd[REM_W-1:0];
  end

  // Stage 4: (ts mod period) >> 6, built from the remainder and the low bits.
  assign y_d = {ts_q[2][PERIOD_SHIFT +: REM_W] - qd_q, ts_q[2][PERIOD_SHIFT-1:6]};

  // Stage 5: y divided by 15625 through a 40-bit reciprocal, four partial
  // products of pieces up to 20 bits wide.
  always_comb begin
    spp_d[0] = 40'(y_q[19:0])  * 40'(RECIP_US[19:0]);
    spp_d[1] = 40'(y_q[19:0])  * 40'(RECIP_US[39:20]);
    spp_d[2] = 40'(y_q[38:20]) * 40'(RECIP_US[19:0]);
    spp_d[3] = 40'(y_q[38:20]) * 40'(RECIP_US[39:20]);
  end

  // Stage 6: seconds inside the period.
  always_comb begin
    logic [78:0] ssum;
    ssum  = 79'(spp_q[0]) + ((79'(spp_q[1]) + 79'(spp_q[2])) << 20)
          + (79'(spp_q[3]) << 40);
    sec_d = ssum[RECIP_US_SHIFT +: SEC_W];
  end

  // Stage 7: quotients by 60, 3600, 86400, 604800 and 2419200, computed side
  // by side. Only their low bits feed the digit step.
  always_comb begin
    logic [50:0] prod;
    prod     = '0;
    quo_d[0] = sec_q[DIG_W-1:0];
    for (int k = 0; k < NUM_RADIX - 1; k++) begin
      prod         = 51'(sec_q) * 51'(RECIP_DIG[k]);
      quo_d[k + 1] = DIG_W'(prod >> DIG_SHIFT[k]);
    end
  end

  // Stage 8: each digit is its quotient minus the radix times the next one.
  // The true value is below the radix, so modular low bits are enough.
  always_comb begin
    for (int k = 0; k < NUM_RADIX - 1; k++) begin
      dig_d[k] = DIG_W'(quo_q[k] - DIG_W'(RADIX[k]) * quo_q[k + 1]);
    end
    dig_d[NUM_RADIX-1] = quo_q[NUM_RADIX-1];
  end

  // Stage 9: digit times its weight for the mode this item carries.
  always_comb begin
    for (int k = 0; k < NUM_RADIX; k++) begin
      term_d[k] = TS_W'(dig_q[k]) * WEIGHT[mode_q[7]][k];
    end
  end

  // Stages 10 and 11: adder tree, the period count enters as the last term.
  always_comb begin
    psum_d[0] = term_q[0] + term_q[1];
    psum_d[1] = term_q[2] + term_q[3];
    psum_d[2] = term_q[4] + term_q[5];
    psum_d[3] = TS_W'(qt_q[7]);
    fsum_d[0] = psum_q[0] + psum_q[1];
    fsum_d[1] = psum_q[2] + psum_q[3];
  end

  // Stage 12: raw mode and the unused code pass the timestamp through.
  assign hash_d = is_hashed(mode_q[10]) ? (fsum_q[0] + fsum_q[1]) : ts_q[10];

  // Payload registers: no reset, they move with the pipeline enable.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ts_q[0]   <= s_axis_tdata;
      mode_q[0] <= cfg_mode_q;
      for (int s = 1; s < NUM_STAGES - 1; s++) begin
        ts_q[s]   <= ts_q[s - 1];
        mode_q[s] <= mode_q[s - 1];
      end
      qt_q[0] <= qt_d;
      for (int s = 1; s < 8; s++) begin
        qt_q[s] <= qt_q[s - 1];
      end
      qpp_q  <= qpp_d;
      qd_q   <= qd_d;
      y_q    <= y_d;
      spp_q  <= spp_d;
      sec_q  <= sec_d;
      quo_q  <= quo_d;
      dig_q  <= dig_d;
      term_q <= term_d;
      psum_q <= psum_d;
      fsum_q <= fsum_d;
      hash_q <= hash_d;
    end
  end

  // The period count must leave a remainder below the odd part of the period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (y_q[Y_W-1:PERIOD_SHIFT-6] < PERIOD_ODD))
    else $error("period remainder out of range");

  // Seconds inside one period stay below the period length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> (sec_q < SECS_PER_PERIOD))
    else $error("seconds inside period out of range");

  // Every digit is below its radix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[7] |-> (dig_q[0] < DIG_W'(RADIX[0])) && (dig_q[1] < DIG_W'(RADIX[1]))
            && (dig_q[2] < DIG_W'(RADIX[2])) && (dig_q[3] < DIG_W'(RADIX[3]))
            && (dig_q[4] < DIG_W'(RADIX[4])) && (dig_q[5] < DIG_W'(RADIX[5])))
    else $error("digit exceeds its radix");

  // A stall freezes the occupancy of every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(v_q))
    else $error("pipeline moved during stall");

endmodule

// ===== tb/tb_timestamp_granularity_hash_top.sv =====
module tb_timestamp_granularity_hash_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tgh_pkg::*;

  // Code seven has no member in the package enum; the block treats it as raw.
  localparam logic [MODE_W-1:0] GRAN_UNUSED = 3'd7;

  localparam logic [TS_W-1:0] US_PER_SEC   = 64'd1000000;
  localparam logic [TS_W-1:0] WORD_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [TS_W-1:0] UNIT_RADIX [NUM_RADIX] = '{60, 60, 24, 7, 4, 12};
  // Lengths in seconds of one minute, hour, day, week, month and full period.
  localparam logic [TS_W-1:0] UNIT_SECS [6] =
    '{60, 3600, 86400, 604800, 2419200, 29030400};

  // Settle time before a config write and at the end.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam int unsigned MAX_REPORTS   = 10;

  // Each random phase runs with its own granularity and one of four idling profiles.
  localparam logic [MODE_W-1:0] PHASE_MODE [NUM_PHASES] = '{
    GRAN_SECOND, GRAN_MONTH, GRAN_RAW, GRAN_HOUR,
    GRAN_UNUSED, GRAN_MINUTE, GRAN_DAY, GRAN_WEEK
  };

  // One row of the directed table. Where typed is set, the expected hash is
  // given in the row; otherwise it comes from the predictor.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TS_W-1:0]   ts;
    logic              typed;
    logic [TS_W-1:0]   hash;
  } stim_row_t;

  // What the sender promises about an offered timestamp until it is accepted.
  typedef struct packed {
    logic            typed;
    logic [TS_W-1:0] hash;
  } offer_note_t;

  localparam int unsigned NUM_ROWS = 23;

  stim_row_t stim_table [NUM_ROWS] = '{
    // Reset leaves the block in raw mode, so the first rows go out unconfigured.
    '{GRAN_RAW,    64'd0,                     1'b1, 64'd0},
    '{GRAN_RAW,    WORD_ONES,                 1'b1, WORD_ONES},
    '{GRAN_RAW,    64'h8000_0000_0000_0001,   1'b1, 64'h8000_0000_0000_0001},
    // The unused code passes the timestamp straight through.
    '{GRAN_UNUSED, 64'h0123_4567_89AB_CDEF,   1'b1, 64'h0123_4567_89AB_CDEF},
    '{GRAN_UNUSED, WORD_ONES,                 1'b1, WORD_ONES},
    '{GRAN_SECOND, 64'd0,                     1'b1, 64'd0},
    // Just below one second truncates to zero seconds.
    '{GRAN_SECOND, 64'd999999,                1'b1, 64'd0},
    '{GRAN_SECOND, 64'd1000000,               1'b1, WORD_ONES / 64'd60},
    '{GRAN_SECOND, 64'd59999999,              1'b0, 64'd0},
    '{GRAN_SECOND, WORD_ONES,                 1'b0, 64'd0},
    '{GRAN_MINUTE, 64'd60000000,              1'b1, WORD_ONES / 64'd60},
    '{GRAN_MINUTE, 64'd3599999999,            1'b0, 64'd0},
    '{GRAN_HOUR,   64'd3600000000,            1'b1, WORD_ONES / 64'd24},
    '{GRAN_HOUR,   64'd86399999999,           1'b0, 64'd0},
    '{GRAN_DAY,    64'd86400000000,           1'b1, WORD_ONES / 64'd7},
    '{GRAN_DAY,    WORD_ONES,                 1'b0, 64'd0},
    '{GRAN_WEEK,   64'd604800000000,          1'b1, WORD_ONES / 64'd4},
    '{GRAN_WEEK,   64'd2419199999999,         1'b0, 64'd0},
    '{GRAN_MONTH,  64'd2419200000000,         1'b1, WORD_ONES / 64'd12},
    // Every radix digit at its maximum, then the first carry into the
    // remainder digit, which alone gives a hash of one.
    '{GRAN_MONTH,  64'd29030399999999,        1'b0, 64'd0},
    '{GRAN_MONTH,  64'd29030400000000,        1'b1, 64'd1},
    '{GRAN_MONTH,  WORD_ONES,                 1'b0, 64'd0},
    '{GRAN_MONTH,  64'd0,                     1'b1, 64'd0}
  };

  // Block ports. Every input has a known value from time zero.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [MODE_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TS_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TS_W-1:0]   m_axis_tdata;

  // Our own copy of the granularity register, updated with every write.
  logic [MODE_W-1:0] gran_mode = GRAN_RAW;

  offer_note_t     offer_notes [$];
  logic [TS_W-1:0] expected_hashes [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  timestamp_granularity_hash_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicts the hash of one timestamp under a given granularity. The seconds
  // are split into mixed-radix digits; the chosen unit leads, then the finer
  // units from coarse to fine, then the coarser ones. The weight shrinks by
  // each visited radix, and the leftover quotient is added at the end.
  function automatic logic [TS_W-1:0] granular_hash(logic [TS_W-1:0] ts,
                                                    logic [MODE_W-1:0] mode);
    logic [TS_W-1:0] digit [NUM_RADIX];
    logic [TS_W-1:0] secs;
    logic [TS_W-1:0] weight;
    logic [TS_W-1:0] acc;
    int              lead;
    int              unit;
    if (mode < GRAN_SECOND || mode > GRAN_MONTH) begin
      return ts;
    end
    secs = ts / US_PER_SEC;
    for (int i = 0; i < NUM_RADIX; i++) begin
      digit[i] = secs % UNIT_RADIX[i];
      secs     = secs / UNIT_RADIX[i];
    end
    lead   = int'(mode) - 1;
    weight = WORD_ONES;
    acc    = '0;
    for (int n = 0; n < NUM_RADIX; n++) begin
      if (n == 0) begin
        unit = lead;
      end else if (n <= lead) begin
        unit = lead - n;
      end else begin
        unit = n;
      end
      weight = weight / UNIT_RADIX[unit];
      acc    = acc + digit[unit] * weight;
    end
    return acc + secs;
  endfunction

  // Draws a timestamp from a mix of shapes: fully random words, short spans of
  // seconds, values right at calendar carries, values near the top of the
  // word, and random words shifted down to reach every magnitude.
  function automatic logic [TS_W-1:0] random_timestamp();
    logic [TS_W-1:0] secs;
    logic [TS_W-1:0] frac;
    case ($urandom_range(4))
      0: begin
        return {$urandom, $urandom};
      end
      1: begin
        secs = 64'($urandom_range(0, 3 * 29030400));
        frac = 64'($urandom_range(0, 999999));
        return secs * US_PER_SEC + frac;
      end
      2: begin
        secs = UNIT_SECS[$urandom_range(5)] * 64'($urandom_range(1, 1000))
               - 64'($urandom_range(1));
        frac = $urandom_range(1) ? 64'd999999 : 64'd0;
        return secs * US_PER_SEC + frac;
      end
      3: begin
        return WORD_ONES - 64'($urandom);
      end
      default: begin
        return {$urandom, $urandom} >> $urandom_range(63);
      end
    endcase
  endfunction

  // Offers one timestamp, after a random gap, and returns at the edge where
  // the transfer happens. tvalid stays high so back-to-back items need no
  // second assignment in the same step.
  task automatic drive_timestamp(input logic [TS_W-1:0] ts, input logic typed,
                                 input logic [TS_W-1:0] typed_hash);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    offer_notes.push_back('{typed, typed_hash});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every expected hash has come back, then
  // lets the pipeline settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (offer_notes.size() != 0 || expected_hashes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the granularity register while the block is idle.
  task automatic set_granularity(input logic [MODE_W-1:0] mode);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gran_mode   = mode;
  endtask

  // Receiver: random back-pressure, plus a long hold-off on request. The
  // hold-off is counted here so the sender can keep offering meanwhile.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scoreboard. Values are sampled at the clock edge, before any register
  // update of that edge lands, so the view is the one the block acts on.
  always @(posedge clk_i) begin
    offer_note_t     note;
    logic [TS_W-1:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        note = offer_notes.pop_front();
        expected_hashes.push_back(note.typed ? note.hash
                                             : granular_hash(s_axis_tdata, gran_mode));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hashes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Unexpected hash transfer: got %h", m_axis_tdata);
          end
        end else begin
          want = expected_hashes.pop_front();
          if (m_axis_tdata !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("Hash mismatch: expected %h, got %h", want, m_axis_tdata);
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the register is only rewritten where the table changes
    // granularity, so the first rows check the reset value of the mode.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (stim_table[r].mode != gran_mode) begin
        set_granularity(stim_table[r].mode);
      end
      drive_timestamp(stim_table[r].ts, stim_table[r].typed, stim_table[r].hash);
    end

    // Random part: each phase drains, reprograms the register and then runs
    // with one of the idling profiles.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_granularity(PHASE_MODE[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      // In the first phase the receiver holds off for a long stretch while
      // the sender keeps pushing, so the pipeline fills and stalls its input.
      if (p == 0) begin
        hold_request = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        drive_timestamp(random_timestamp(), 1'b0, '0);
      end
    end

    wait_drained();
    if (expected_hashes.size() != 0) begin
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tgh_pkg.sv
rtl/timestamp_granularity_hash_top.sv
tb/tb_timestamp_granularity_hash_top.sv
